// File: src/hjd_pkg.sv
// hjd_pkg: shared types, constants and jamo tables for the hangul jamo decomposer
// no dependencies; imported by every module of the block
`default_nettype none

package hjd_pkg;

  // code point ranges and special characters
  localparam logic [20:0] SYL_FIRST  = 21'h00AC00;
  localparam logic [20:0] SYL_LAST   = 21'h00D7A3;
  localparam logic [20:0] JAMO_FIRST = 21'h003131;
  localparam logic [20:0] JAMO_LAST  = 21'h00318E;
  localparam logic [20:0] CODE_NL    = 21'h00000A;
  localparam logic [15:0] MEDIAL_FIRST = 16'h314F;
  localparam logic [7:0]  CH_NL    = 8'h0A;
  localparam logic [7:0]  CH_SPACE = 8'h20;

  // utf-8 byte marks
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  // reciprocal constants: idx / 588 and idx / 28 for idx below 11172
  localparam logic [13:0] LI_RECIP = 14'd14267;
  localparam int          LI_SHIFT = 23;
  localparam logic [13:0] Q_RECIP  = 14'd9363;
  localparam int          Q_SHIFT  = 18;
  localparam logic [4:0]  N_INITIAL = 5'd19;
  localparam logic [4:0]  N_MEDIAL  = 5'd21;
  localparam logic [4:0]  N_FINAL   = 5'd28;

  // most bytes one character can produce
  localparam int MAX_BYTES = 9;

  typedef enum logic [1:0] {
    KIND_JAMO,
    KIND_SYL,
    KIND_NL,
    KIND_OTHER
  } kind_t;

  // one burst of output bytes, bytes[0] goes out first
  typedef struct packed {
    logic [3:0]                 cnt;
    logic [MAX_BYTES-1:0][7:0]  bytes;
  } burst_t;

  // initial consonant index to compatibility jamo
  function automatic logic [15:0] init_jamo(input logic [4:0] li);
    logic [15:0] r;
    case (li)
      5'd0:  r = 16'h3131;
      5'd1:  r = 16'h3132;
      5'd2:  r = 16'h3134;
      5'd3:  r = 16'h3137;
      5'd4:  r = 16'h3138;
      5'd5:  r = 16'h3139;
      5'd6:  r = 16'h3141;
      5'd7:  r = 16'h3142;
      5'd8:  r = 16'h3143;
      5'd9:  r = 16'h3145;
      5'd10: r = 16'h3146;
      5'd11: r = 16'h3147;
      5'd12: r = 16'h3148;
      5'd13: r = 16'h3149;
      5'd14: r = 16'h314A;
      5'd15: r = 16'h314B;
      5'd16: r = 16'h314C;
      5'd17: r = 16'h314D;
      5'd18: r = 16'h314E;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // final consonant index to compatibility jamo, index zero means none
  function automatic logic [15:0] final_jamo(input logic [4:0] ti);
    logic [15:0] r;
    case (ti)
      5'd1:  r = 16'h3131;
      5'd2:  r = 16'h3132;
      5'd3:  r = 16'h3133;
      5'd4:  r = 16'h3134;
      5'd5:  r = 16'h3135;
      5'd6:  r = 16'h3136;
      5'd7:  r = 16'h3137;
      5'd8:  r = 16'h3139;
      5'd9:  r = 16'h313A;
      5'd10: r = 16'h313B;
      5'd11: r = 16'h313C;
      5'd12: r = 16'h313D;
      5'd13: r = 16'h313E;
      5'd14: r = 16'h313F;
      5'd15: r = 16'h3140;
      5'd16: r = 16'h3141;
      5'd17: r = 16'h3142;
      5'd18: r = 16'h3144;
      5'd19: r = 16'h3145;
      5'd20: r = 16'h3146;
      5'd21: r = 16'h3147;
      5'd22: r = 16'h3148;
      5'd23: r = 16'h314A;
      5'd24: r = 16'h314B;
      5'd25: r = 16'h314C;
      5'd26: r = 16'h314D;
      5'd27: r = 16'h314E;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // three-byte utf-8 encoding, first byte in the low bits
  function automatic logic [2:0][7:0] utf8_3(input logic [15:0] c);
    logic [2:0][7:0] r;
    r[0] = UTF8_LEAD3 | {4'h0, c[15:12]};
    r[1] = UTF8_CONT  | {2'b00, c[11:6]};
    r[2] = UTF8_CONT  | {2'b00, c[5:0]};
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/hjd_if.sv
// hjd_in_if and hjd_out_if: valid/ready channels of the hangul jamo decomposer
// no dependencies
`default_nettype none

interface hjd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface hjd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: src/hjd_split.sv
// hjd_split: classifies a finished code point and builds its output byte burst
// depends on hjd_pkg
`default_nettype none

module hjd_split (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  wire logic [20:0]    push_code,
  output logic                push_ready,
  output logic                word_valid,
  output hjd_pkg::burst_t     word,
  input  wire logic           word_ready
);
  import hjd_pkg::*;

  logic        a_valid;
  logic [20:0] a_code;
  logic        a_adv;

  kind_t       a_kind;
  logic [13:0] a_idx;
  logic [15:0] a_diff;
  logic [27:0] li_prod;
  logic [27:0] q_prod;

  logic        b_valid;
  kind_t       b_kind;
  logic [15:0] b_code;
  logic [13:0] b_idx;
  logic [4:0]  b_li;
  logic [8:0]  b_q28;

  logic [13:0] q28x;
  logic [13:0] ti_full;
  logic [8:0]  li21;
  logic [8:0]  vi_full;
  logic [4:0]  vi;
  logic [4:0]  ti;
  logic        prev_was_space;
  burst_t      burst;

  // stage handshakes
  assign a_adv      = !b_valid || word_ready;
  assign push_ready = !a_valid || a_adv;
  assign word_valid = b_valid;
  assign word       = burst;

  // stage a: finished code point
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (push_ready) begin
      a_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ready && push_valid) begin
      a_code <= push_code;
    end
  end

  // classify and divide the syllable index by 588 and by 28
  always_comb begin
    if (a_code inside {[JAMO_FIRST:JAMO_LAST]}) begin
      a_kind = KIND_JAMO;
    end else if (a_code inside {[SYL_FIRST:SYL_LAST]}) begin
      a_kind = KIND_SYL;
    end else if (a_code == CODE_NL) begin
      a_kind = KIND_NL;
    end else begin
      a_kind = KIND_OTHER;
    end
  end

  assign a_diff  = a_code[15:0] - SYL_FIRST[15:0];
  assign a_idx   = a_diff[13:0];
  assign li_prod = {14'd0, a_idx} * {14'd0, LI_RECIP};
  assign q_prod  = {14'd0, a_idx} * {14'd0, Q_RECIP};

  // stage b: classified code point with quotients
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_valid) begin
      b_kind <= a_kind;
      b_code <= a_code[15:0];
      b_idx  <= a_idx;
      b_li   <= li_prod[LI_SHIFT +: 5];
      b_q28  <= q_prod[Q_SHIFT +: 9];
    end
  end

  // remainders: ti = idx - 28 * q, vi = q - 21 * li
  assign q28x    = {b_q28, 5'b00000} - {3'b000, b_q28, 2'b00};
  assign ti_full = b_idx - q28x;
  assign ti      = ti_full[4:0];
  assign li21    = {b_li, 4'b0000} + {2'b00, b_li, 2'b00} + {4'b0000, b_li};
  assign vi_full = b_q28 - li21;
  assign vi      = vi_full[4:0];

  // output burst
  always_comb begin
    burst = '0;
    case (b_kind)
      KIND_JAMO: begin
        burst.cnt        = 4'd3;
        burst.bytes[2:0] = utf8_3(b_code);
      end
      KIND_SYL: begin
        burst.bytes[2:0] = utf8_3(init_jamo(b_li));
        burst.bytes[5:3] = utf8_3(MEDIAL_FIRST + {11'd0, vi});
        burst.bytes[8:6] = utf8_3(final_jamo(ti));
        burst.cnt        = (ti != 5'd0) ? 4'd9 : 4'd6;
      end
      KIND_NL: begin
        burst.cnt      = 4'd1;
        burst.bytes[0] = CH_NL;
      end
      default: begin
        burst.cnt      = prev_was_space ? 4'd0 : 4'd1;
        burst.bytes[0] = CH_SPACE;
      end
    endcase
  end

  // space collapsing state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_space <= 1'b0;
    end else if (b_valid && word_ready) begin
      prev_was_space <= (b_kind == KIND_OTHER);
    end
  end

  // syllable indices stay in their tables
  a_syl_range: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_kind == KIND_SYL) |-> (b_li < N_INITIAL && vi < N_MEDIAL && ti < N_FINAL))
    else $error("syllable index out of range");

  // a stalled stage a keeps its code point
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_adv) |=> (a_valid && $stable(a_code)))
    else $error("stage a lost its code point under stall");

  // a stalled stage b keeps its word
  b_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !word_ready) |=> (b_valid && $stable(b_kind) && $stable(b_code)))
    else $error("stage b lost its word under stall");

endmodule

`default_nettype wire

// File: src/hangul_jamo_decomposer_core.sv
// hangul_jamo_decomposer_core: utf-8 gathering, burst output register and top level
// depends on hjd_pkg, hjd_if and hjd_split
//
// usage
//   in_ch carries one word per input byte: cmd 0 with a utf-8 byte in data_byte,
//   or cmd 1 to flush the character still being gathered at end of stream.
//   out_ch carries one utf-8 byte per word; last marks the final byte caused by
//   one input word. a character is emitted when the next lead or ascii byte
//   arrives, or on a flush.
// pipeline and throughput
//   the first output byte of a character becomes valid from the burst register
//   after the input word that ends it (the next lead or ascii byte, or a flush)
//   is accepted: it passes two register stages of classification and index
//   splitting, then the burst register. in_ch takes one word per cycle while
//   each character yields at most one byte and out_ch does not stall; a
//   character's burst of 0, 1, 3, 6 or 9 bytes leaves at one byte per cycle
//   from the burst shift register while out_ch is ready. a new burst loads in
//   the cycle the last byte of the previous one is taken.
// reset and stall
//   rst (synchronous) clears the gathered code point, the space state and all
//   stage valid flags. when out_ch stalls, the burst register holds, then the
//   two stages fill, then in_ch.ready drops.
`default_nettype none

module hangul_jamo_decomposer_core (
  input  wire logic  clk,
  input  wire logic  rst,
  hjd_in_if.sink     in_ch,
  hjd_out_if.source  out_ch
);
  import hjd_pkg::*;

  logic        pending_valid;
  logic [20:0] pending_code;
  logic [20:0] start_code;
  logic        in_take;
  logic        is_cont;
  logic        emits;
  logic        push_valid;
  logic        push_ready;

  logic        word_valid;
  burst_t      word;
  logic        word_ready;
  logic        out_take;

  logic [3:0]                burst_cnt;
  logic [MAX_BYTES-1:0][7:0] burst_bytes;

  assign in_take    = in_ch.valid && in_ch.ready;
  assign is_cont    = (in_ch.data_byte[7:6] == 2'b10);
  assign emits      = pending_valid && (in_ch.cmd || !is_cont);
  assign push_valid = in_ch.valid && emits;
  assign in_ch.ready = push_ready;

  // payload bits of a lead or ascii byte
  always_comb begin
    if (!in_ch.data_byte[7]) begin
      start_code = {13'd0, in_ch.data_byte};
    end else if (in_ch.data_byte[7:5] == 3'b110) begin
      start_code = {16'd0, in_ch.data_byte[4:0]};
    end else if (in_ch.data_byte[7:4] == 4'b1110) begin
      start_code = {17'd0, in_ch.data_byte[3:0]};
    end else begin
      start_code = {18'd0, in_ch.data_byte[2:0]};
    end
  end

  // code point gathering
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_code  <= '0;
    end else if (in_take) begin
      if (in_ch.cmd) begin
        pending_valid <= 1'b0;
        pending_code  <= '0;
      end else if (is_cont) begin
        if (pending_valid) begin
          pending_code <= {pending_code[14:0], in_ch.data_byte[5:0]};
        end
      end else begin
        pending_valid <= 1'b1;
        pending_code  <= start_code;
      end
    end
  end

  hjd_split u_split (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_code  (pending_code),
    .push_ready (push_ready),
    .word_valid (word_valid),
    .word       (word),
    .word_ready (word_ready)
  );

  // burst shift register
  assign out_take   = out_ch.valid && out_ch.ready;
  assign word_ready = (burst_cnt == 4'd0) || (burst_cnt == 4'd1 && out_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_cnt <= '0;
    end else if (word_valid && word_ready) begin
      burst_cnt <= word.cnt;
    end else if (out_take) begin
      burst_cnt <= burst_cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      burst_bytes <= word.bytes;
    end else if (out_take) begin
      burst_bytes <= {8'h00, burst_bytes[MAX_BYTES-1:1]};
    end
  end

  assign out_ch.valid    = (burst_cnt != 4'd0);
  assign out_ch.out_byte = burst_bytes[0];
  assign out_ch.last     = (burst_cnt == 4'd1);

  // a burst keeps going after a byte is taken
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (out_take && burst_cnt > 4'd1) |=> (out_ch.valid && burst_cnt == $past(burst_cnt) - 4'd1))
    else $error("burst dropped bytes");

  // a lead or ascii byte starts a new code point
  a_lead_starts: assert property (@(posedge clk) disable iff (rst)
    (in_take && !in_ch.cmd && !is_cont) |=> pending_valid)
    else $error("lead byte did not start a code point");

  // a flush leaves nothing pending
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_ch.cmd) |=> (!pending_valid && pending_code == '0))
    else $error("flush left a code point pending");

endmodule

`default_nettype wire
